// File: design/tbim_pkg.sv
// ----------------------------------------------------------------------------
// tbim_pkg
// Shared constants and types for the two-body invariant mass pipeline.
// ----------------------------------------------------------------------------
package tbim_pkg;

  localparam int MOMENTUM_BITS_DEFAULT = 20;
  localparam int MASS_W   = 21;
  localparam int CFG_W    = 32;
  localparam int ADDR_W   = 3;
  localparam int FRAC_SHIFT = 24;  // 2^-24 GeV^2 -> 2^-48 GeV^2
  localparam int OUT_SHIFT  = 12;  // 2^-24 GeV -> 2^-12 GeV

  localparam logic [MASS_W-1:0] MASS_MAX = 21'h1FFFFF;

  localparam logic [CFG_W-1:0] FIRST_MSQ_RESET  = 32'd326821;
  localparam logic [CFG_W-1:0] SECOND_MSQ_RESET = 32'd14769832;

  // register index, taken from paddr[2]
  localparam logic REG_FIRST_MSQ  = 1'b0;
  localparam logic REG_SECOND_MSQ = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] first_msq;
    logic [CFG_W-1:0] second_msq;
  } cfg_t;

endpackage

// File: design/tbim_cfg.sv
// ----------------------------------------------------------------------------
// tbim_cfg
// APB register file holding the two hypothesis masses squared.
// ----------------------------------------------------------------------------
module tbim_cfg
  import tbim_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_msq  <= FIRST_MSQ_RESET;
      cfg.second_msq <= SECOND_MSQ_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_FIRST_MSQ:  cfg.first_msq  <= pwdata;
        REG_SECOND_MSQ: cfg.second_msq <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST_MSQ:  prdata = cfg.first_msq;
      REG_SECOND_MSQ: prdata = cfg.second_msq;
      default:        prdata = '0;
    endcase
  end

endmodule

// File: design/tbim_isqrt.sv
// ----------------------------------------------------------------------------
// tbim_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tbim_isqrt
  import tbim_pkg::*;
#(
  parameter int ROOT_W = 34,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [LANES-1:0][2*ROOT_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_valid,
  output logic [LANES-1:0][ROOT_W-1:0]       out_root,
  output logic [SIDE_W-1:0]                  out_side
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;
  localparam int CUR_W = ROOT_W + 3;

  logic                           vld    [ROOT_W];
  logic [SIDE_W-1:0]              side_q [ROOT_W];
  logic [LANES-1:0][RAD_W-1:0]    rad_q  [ROOT_W];
  logic [LANES-1:0][REM_W-1:0]    rem_q  [ROOT_W];
  logic [LANES-1:0][ROOT_W-1:0]   root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                         p_vld;
    logic [SIDE_W-1:0]            p_side;
    logic [LANES-1:0][RAD_W-1:0]  p_rad;
    logic [LANES-1:0][REM_W-1:0]  p_rem;
    logic [LANES-1:0][ROOT_W-1:0] p_root;
    logic [LANES-1:0][RAD_W-1:0]  n_rad;
    logic [LANES-1:0][REM_W-1:0]  n_rem;
    logic [LANES-1:0][ROOT_W-1:0] n_root;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_side = in_side;
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_side = side_q[k-1];
      assign p_rad  = rad_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CUR_W-1:0] cur;
      logic [CUR_W-1:0] trial;
      logic             ge;
      assign cur   = {p_rem[l], p_rad[l][RAD_W-1 -: 2]};
      assign trial = CUR_W'({p_root[l], 2'b01});
      assign ge    = (cur >= trial);
      assign n_rem[l]  = ge ? REM_W'(cur - trial) : REM_W'(cur);
      assign n_root[l] = {p_root[l][ROOT_W-2:0], ge};
      assign n_rad[l]  = {p_rad[l][RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k] <= p_side;
        rad_q[k]  <= n_rad;
        rem_q[k]  <= n_rem;
        root_q[k] <= n_root;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];

endmodule

// File: design/two_body_invariant_mass.sv
// ----------------------------------------------------------------------------
// two_body_invariant_mass
// Fixed-point invariant mass of a two-track pair, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one track pair per clock and returns one pair mass per clock while
// the result side does not stall. Each request passes through a fixed
// pipeline: three stages of magnitude, square and sum; a square-root pipeline
// of E_W stages for both daughter energies; four stages for the energy sum,
// its partial products, its square and the radicand; a second square-root
// pipeline of ETOT_W stages for the mass; and an output register. A stall on
// the result side freezes the whole pipeline, so nothing is lost or repeated.
// The mass hypotheses are read live from the registers, so write them only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module two_body_invariant_mass
  import tbim_pkg::*;
#(
  parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // pair requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [MOMENTUM_BITS-1:0] first_px,
  input  logic signed [MOMENTUM_BITS-1:0] first_py,
  input  logic signed [MOMENTUM_BITS-1:0] first_pz,
  input  logic signed [MOMENTUM_BITS-1:0] second_px,
  input  logic signed [MOMENTUM_BITS-1:0] second_py,
  input  logic signed [MOMENTUM_BITS-1:0] second_pz,
  // mass results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [MASS_W-1:0]               pair_mass,
  output logic                            unphysical,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ADDR_W-1:0]               paddr,
  input  logic [CFG_W-1:0]                pwdata,
  output logic [CFG_W-1:0]                prdata,
  output logic                            pready
);

  localparam int M       = MOMENTUM_BITS;
  localparam int SQ_W    = 2 * M;                      // one track |p|^2
  localparam int PSQ_W   = 2 * M + 2;                  // |p1+p2|^2
  localparam int NRM_W   = ((SQ_W > CFG_W) ? SQ_W : CFG_W) + 1;
  localparam int E_W     = (NRM_W + FRAC_SHIFT + 1) / 2;
  localparam int ERAD_W  = 2 * E_W;
  localparam int ETOT_W  = E_W + 1;
  localparam int ESQ_W   = 2 * ETOT_W;
  localparam int H       = (ETOT_W + 1) / 2;           // low half of etot
  localparam int HI_W    = ETOT_W - H;
  localparam int PSH_W   = PSQ_W + FRAC_SHIFT;
  localparam int D_W     = ((ESQ_W > PSH_W) ? ESQ_W : PSH_W) + 1;

  cfg_t cfg;
  logic adv;

  // Advance whenever the output register is free or being drained.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  tbim_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // Stage 1: component magnitudes of each track and of the pair sum
  // --------------------------------------------------------------------------
  logic                signed [M-1:0] a_in [3];
  logic                signed [M-1:0] b_in [3];
  logic [M-1:0]        a_mag [3];
  logic [M-1:0]        b_mag [3];
  logic [M:0]          s_mag [3];
  logic                v1;

  assign a_in[0] = first_px;
  assign a_in[1] = first_py;
  assign a_in[2] = first_pz;
  assign b_in[0] = second_px;
  assign b_in[1] = second_py;
  assign b_in[2] = second_pz;

  for (genvar c = 0; c < 3; c++) begin : g_mag
    logic [M:0] sum;
    assign sum = {a_in[c][M-1], a_in[c]} + {b_in[c][M-1], b_in[c]};
    always_ff @(posedge clk) begin
      if (adv) begin
        a_mag[c] <= a_in[c][M-1] ? M'(-a_in[c]) : M'(a_in[c]);
        b_mag[c] <= b_in[c][M-1] ? M'(-b_in[c]) : M'(b_in[c]);
        s_mag[c] <= sum[M] ? (M+1)'(-sum) : sum;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]  a_sq [3];
  logic [SQ_W-1:0]  b_sq [3];
  logic [PSQ_W-1:0] s_sq [3];
  logic             v2;

  for (genvar c = 0; c < 3; c++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        a_sq[c] <= a_mag[c] * a_mag[c];
        b_sq[c] <= b_mag[c] * b_mag[c];
        s_sq[c] <= s_mag[c] * s_mag[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: |p|^2 + m^2 per track, and |p1+p2|^2
  // --------------------------------------------------------------------------
  logic [NRM_W-1:0] n1, n2;
  logic [PSQ_W-1:0] psq3;
  logic             v3;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1   <= NRM_W'(a_sq[0]) + NRM_W'(a_sq[1]) + NRM_W'(a_sq[2]) + NRM_W'(cfg.first_msq);
      n2   <= NRM_W'(b_sq[0]) + NRM_W'(b_sq[1]) + NRM_W'(b_sq[2]) + NRM_W'(cfg.second_msq);
      psq3 <= s_sq[0] + s_sq[1] + s_sq[2];
    end
  end

  // --------------------------------------------------------------------------
  // Energies: both daughters share one root pipeline, |p1+p2|^2 rides along
  // --------------------------------------------------------------------------
  logic [1:0][ERAD_W-1:0] e_rad;
  logic [1:0][E_W-1:0]    e_root;
  logic [PSQ_W-1:0]       psq_e;
  logic                   v_e;

  assign e_rad[0] = ERAD_W'({n1, {FRAC_SHIFT{1'b0}}});
  assign e_rad[1] = ERAD_W'({n2, {FRAC_SHIFT{1'b0}}});

  tbim_isqrt #(
    .ROOT_W (E_W),
    .LANES  (2),
    .SIDE_W (PSQ_W)
  ) u_energy (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .in_rad    (e_rad),
    .in_side   (psq3),
    .out_valid (v_e),
    .out_root  (e_root),
    .out_side  (psq_e)
  );

  // --------------------------------------------------------------------------
  // Stage 4: total energy
  // --------------------------------------------------------------------------
  logic [ETOT_W-1:0] etot;
  logic [PSQ_W-1:0]  psq4;
  logic              v4;

  always_ff @(posedge clk) begin
    if (adv) begin
      etot <= ETOT_W'(e_root[0]) + ETOT_W'(e_root[1]);
      psq4 <= psq_e;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: partial products of etot^2
  // --------------------------------------------------------------------------
  logic [2*HI_W-1:0]   pp_hh;
  logic [HI_W+H-1:0]   pp_hl;
  logic [2*H-1:0]      pp_ll;
  logic [PSQ_W-1:0]    psq5;
  logic                v5;

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_hh <= etot[ETOT_W-1:H] * etot[ETOT_W-1:H];
      pp_hl <= etot[ETOT_W-1:H] * etot[H-1:0];
      pp_ll <= etot[H-1:0] * etot[H-1:0];
      psq5  <= psq4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: etot^2
  // --------------------------------------------------------------------------
  logic [ESQ_W-1:0] esq;
  logic [PSQ_W-1:0] psq6;
  logic             v6;

  always_ff @(posedge clk) begin
    if (adv) begin
      esq  <= (ESQ_W'(pp_hh) << (2 * H)) + (ESQ_W'(pp_hl) << (H + 1)) + ESQ_W'(pp_ll);
      psq6 <= psq5;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: radicand D = etot^2 - |p1+p2|^2 * 2^24; flag negative
  // --------------------------------------------------------------------------
  logic [D_W-1:0]   diff;
  logic [ESQ_W-1:0] m_rad;
  logic             neg7;
  logic             v7;

  assign diff = D_W'(esq) - D_W'({psq6, {FRAC_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (adv) begin
      neg7  <= diff[D_W-1];
      m_rad <= diff[D_W-1] ? '0 : diff[ESQ_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Mass root pipeline, the negative flag rides along
  // --------------------------------------------------------------------------
  logic [0:0][ESQ_W-1:0]  m_rad_l;
  logic [0:0][ETOT_W-1:0] m_root;
  logic                   neg_m;
  logic                   v_m;
  logic [ETOT_W-1:0]      m_shr;

  assign m_rad_l[0] = m_rad;

  tbim_isqrt #(
    .ROOT_W (ETOT_W),
    .LANES  (1),
    .SIDE_W (1)
  ) u_mass (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v7),
    .in_rad    (m_rad_l),
    .in_side   (neg7),
    .out_valid (v_m),
    .out_root  (m_root),
    .out_side  (neg_m)
  );

  assign m_shr = m_root[0] >> OUT_SHIFT;

  // --------------------------------------------------------------------------
  // Output register: scale to 2^-12 GeV, zero if unphysical, saturate, hold while stalled
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      unphysical <= neg_m;
      if (neg_m) begin
        pair_mass <= '0;
      end else if (m_shr > ETOT_W'(MASS_MAX)) begin
        pair_mass <= MASS_MAX;
      end else begin
        pair_mass <= MASS_W'(m_shr);
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v_e;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v_m;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_unphys_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unphysical |-> pair_mass == '0)
    else $error("unphysical result with nonzero mass");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v7)
    else $error("pipeline not empty after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3, v4, v5, v6, v7}) && $stable(esq) && $stable(etot))
    else $error("pipeline moved while stalled");

  a_neg_rad: assert property (@(posedge clk) disable iff (rst)
    adv && v7 && neg7 |-> m_rad == '0)
    else $error("negative radicand passed to mass root");

endmodule
